/* rtl/addressable_led_chain_driver_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the LED chain driver checkers
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_CHAIN_DRIVER_CORE_DEFINES_SVH
`define ADDRESSABLE_LED_CHAIN_DRIVER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define ALED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define ALED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/aled_pkg.sv */
// ----------------------------------------------------------------------------
// aled_pkg
// Types and constants of the addressable LED chain driver.
// ----------------------------------------------------------------------------
package aled_pkg;

    localparam int LED_COUNT_DEF = 64;
    localparam int BITS_PER_LED  = 24;

    localparam logic [7:0] ONE_HIGH_RST    = 8'd58;
    localparam logic [7:0] ZERO_HIGH_RST   = 8'd29;
    localparam logic [7:0] SLOT_TICKS_RST  = 8'd90;
    localparam logic [7:0] RESET_SLOTS_RST = 8'd50;

    // operation codes
    localparam logic [1:0] OP_SET_COLOR = 2'd0;
    localparam logic [1:0] OP_START     = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ONE_HIGH    = 2'd0;
    localparam logic [1:0] CFG_ZERO_HIGH   = 2'd1;
    localparam logic [1:0] CFG_SLOT_TICKS  = 2'd2;
    localparam logic [1:0] CFG_RESET_SLOTS = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_out_item;

endpackage

/* rtl/aled_ram.sv */
// ----------------------------------------------------------------------------
// aled_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aled_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/addressable_led_chain_driver_core.sv */
// ----------------------------------------------------------------------------
// addressable_led_chain_driver_core: result in the cycle after each transfer in.
// Throughput one item per cycle while the input is not stalled; pixel store is
// one RAM, one write, one read. Reset clears every pixel, input stalled meanwhile.
// ----------------------------------------------------------------------------
module addressable_led_chain_driver_core #(
    parameter int LED_COUNT = aled_pkg::LED_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aled_pkg::t_in_item  i_in_data,
    // result output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aled_pkg::t_out_item o_out_data,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    localparam int IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int PIX_W  = aled_pkg::BITS_PER_LED;
    localparam int BIT_W  = $clog2(aled_pkg::BITS_PER_LED);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_GAP
    } t_phase;

    t_phase r_phase, n_phase;
    logic [IDX_W-1:0] r_led, n_led;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [7:0]       r_tick, n_tick;
    logic [7:0]       r_gap, n_gap;
    logic [PIX_W-1:0] r_cur_bits;
    logic             r_load, n_load;
    logic             r_clr, n_clr;
    logic [IDX_W-1:0] r_clr_addr, n_clr_addr;

    logic [7:0] r_one_high, r_zero_high, r_slot_ticks, r_reset_slots;

    logic                r_out_valid, n_out_valid;
    aled_pkg::t_out_item r_out_data, n_out_data;

    logic             w_accept;
    logic             w_was_busy;
    logic [7:0]       w_slot_len;
    logic [7:0]       w_tick_inc;
    logic [7:0]       w_gap_inc;
    logic             w_slot_end;
    logic [BIT_W-1:0] w_bit_sel;
    logic [PIX_W-1:0] w_bits;
    logic             w_cur_bit;
    logic [7:0]       w_high;
    logic [IDX_W:0]   w_led_next;
    logic [IDX_W+7:0] w_pix_wide;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [PIX_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [PIX_W-1:0] w_rdata;

    aled_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LED_COUNT),
        .ADDR_W(IDX_W)
    ) u_pixels (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_in_stall  = r_clr | (r_out_valid & i_out_stall);
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // fetched pixel lands in the cycle after the read was issued
    assign w_bits = r_load ? w_rdata : r_cur_bits;

    always_comb begin
        n_phase     = r_phase;
        n_led       = r_led;
        n_bit       = r_bit;
        n_tick      = r_tick;
        n_gap       = r_gap;
        n_load      = 1'b0;
        n_clr       = r_clr;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_data  = r_out_data;

        w_was_busy = (r_phase != PH_IDLE);
        w_slot_len = (r_slot_ticks == 8'd0) ? 8'd1 : r_slot_ticks;
        w_tick_inc = r_tick + 8'd1;
        w_gap_inc  = r_gap + 8'd1;
        w_slot_end = (w_tick_inc >= w_slot_len);
        w_bit_sel  = BIT_W'(aled_pkg::BITS_PER_LED - 1) - r_bit;
        w_cur_bit  = w_bits[w_bit_sel];
        w_high     = w_cur_bit ? r_one_high : r_zero_high;
        w_led_next = {1'b0, r_led} + (IDX_W+1)'(1);
        w_pix_wide = {{IDX_W{1'b0}}, i_in_data.pixel_index};

        w_we    = 1'b0;
        w_waddr = w_pix_wide[IDX_W-1:0];
        w_wdata = {i_in_data.green, i_in_data.red, i_in_data.blue};
        w_raddr = w_led_next[IDX_W-1:0];

        if (r_clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
            n_clr_addr = r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(LED_COUNT - 1)) begin
                n_clr = 1'b0;
            end
        end

        if (w_accept) begin
            n_out_valid           = 1'b1;
            n_out_data            = '0;
            n_out_data.busy_res   = w_was_busy;
            case (i_in_data.operation)
                aled_pkg::OP_SET_COLOR: begin
                    if (w_was_busy) begin
                        n_out_data.rejected = 1'b1;
                    end else if (32'(i_in_data.pixel_index) < 32'(LED_COUNT)) begin
                        w_we = 1'b1;
                    end
                end
                aled_pkg::OP_START: begin
                    if (w_was_busy) begin
                        n_out_data.rejected = 1'b1;
                    end else begin
                        n_phase  = PH_DATA;
                        n_led    = '0;
                        n_bit    = '0;
                        n_tick   = '0;
                        n_gap    = '0;
                        w_raddr  = '0;
                        n_load   = 1'b1;
                        n_out_data.busy_res = 1'b1;
                    end
                end
                aled_pkg::OP_TICK: begin
                    if (r_phase == PH_DATA) begin
                        n_out_data.line_level = (r_tick < w_high);
                        if (w_slot_end) begin
                            n_tick = '0;
                            if (r_bit == BIT_W'(aled_pkg::BITS_PER_LED - 1)) begin
                                n_bit = '0;
                                if (w_led_next == (IDX_W+1)'(LED_COUNT)) begin
                                    n_led = '0;
                                    n_gap = '0;
                                    if (r_reset_slots == 8'd0) begin
                                        n_phase = PH_IDLE;
                                        n_out_data.frame_done = 1'b1;
                                    end else begin
                                        n_phase = PH_GAP;
                                    end
                                end else begin
                                    // next pixel is read now, used from the next tick
                                    n_led  = w_led_next[IDX_W-1:0];
                                    n_load = 1'b1;
                                end
                            end else begin
                                n_bit = r_bit + BIT_W'(1);
                            end
                        end else begin
                            n_tick = w_tick_inc;
                        end
                    end else if (r_phase == PH_GAP) begin
                        if (w_slot_end) begin
                            n_tick = '0;
                            if (w_gap_inc >= r_reset_slots) begin
                                n_gap   = '0;
                                n_phase = PH_IDLE;
                                n_out_data.frame_done = 1'b1;
                            end else begin
                                n_gap = w_gap_inc;
                            end
                        end else begin
                            n_tick = w_tick_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_led         <= '0;
            r_bit         <= '0;
            r_tick        <= '0;
            r_gap         <= '0;
            r_load        <= 1'b0;
            r_clr         <= 1'b1;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
            r_one_high    <= aled_pkg::ONE_HIGH_RST;
            r_zero_high   <= aled_pkg::ZERO_HIGH_RST;
            r_slot_ticks  <= aled_pkg::SLOT_TICKS_RST;
            r_reset_slots <= aled_pkg::RESET_SLOTS_RST;
        end else begin
            r_phase     <= n_phase;
            r_led       <= n_led;
            r_bit       <= n_bit;
            r_tick      <= n_tick;
            r_gap       <= n_gap;
            r_load      <= n_load;
            r_clr       <= n_clr;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    aled_pkg::CFG_ONE_HIGH:    r_one_high    <= i_cfg_data;
                    aled_pkg::CFG_ZERO_HIGH:   r_zero_high   <= i_cfg_data;
                    aled_pkg::CFG_SLOT_TICKS:  r_slot_ticks  <= i_cfg_data;
                    aled_pkg::CFG_RESET_SLOTS: r_reset_slots <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_cur_bits <= w_bits;
        r_out_data <= n_out_data;
    end

endmodule

/* rtl/aled_chk.sv */
// ----------------------------------------------------------------------------
// aled_chk
// Port-level checks on the LED chain driver, bound into the driver core module.
// ----------------------------------------------------------------------------
`include "addressable_led_chain_driver_core_defines.svh"

module aled_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input aled_pkg::t_out_item o_out_data
);

    // a held result keeps its transfer pending unchanged
    `ALED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // no new item while the output register is full and stalled
    `ALED_ASSERT_NOW(a_skid, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall, "input taken with output blocked")

    `ALED_ASSERT_NOW(a_rej_busy, i_clk, i_rst_n, o_out_valid && o_out_data.rejected, o_out_data.busy_res, "reject without busy")

    `ALED_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_out_valid && o_out_data.frame_done, o_out_data.busy_res && !o_out_data.rejected, "frame end outside a frame")

endmodule

bind addressable_led_chain_driver_core aled_chk u_aled_chk (.*);

/* tb/sv/led_wave_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_wave_tb_pkg
// Scoreboard for the LED chain driver. It keeps its own pixel store and frame
// sequencer, works out the wire level and status flags for every input
// transfer, and checks each result transfer against the oldest one awaited.
// ----------------------------------------------------------------------------
package led_wave_tb_pkg;
    import aled_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {SEND_IDLE, SEND_DATA, SEND_GAP} t_send_phase;

    class t_led_wave_scoreboard;
        logic [23:0] pixels [LED_COUNT_DEF];
        int          led_pos;
        int          bit_pos;
        logic [7:0]  tick_pos;
        logic [7:0]  gap_cnt;
        t_send_phase phase;
        logic [23:0] cur_bits;
        logic [7:0]  one_high;
        logic [7:0]  zero_high;
        logic [7:0]  slot_len;
        logic [7:0]  gap_slots;
        t_out_item   awaited_wave [$];
        int          failures;

        function new();
            foreach (pixels[i]) pixels[i] = '0;
            led_pos   = 0;
            bit_pos   = 0;
            tick_pos  = '0;
            gap_cnt   = '0;
            phase     = SEND_IDLE;
            cur_bits  = '0;
            one_high  = ONE_HIGH_RST;
            zero_high = ZERO_HIGH_RST;
            slot_len  = SLOT_TICKS_RST;
            gap_slots = RESET_SLOTS_RST;
            failures  = 0;
        endfunction

        function void write_timing(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_ONE_HIGH:    one_high  = val;
                CFG_ZERO_HIGH:   zero_high = val;
                CFG_SLOT_TICKS:  slot_len  = val;
                CFG_RESET_SLOTS: gap_slots = val;
                default: ;
            endcase
        endfunction

        function bit frame_active();
            return phase != SEND_IDLE;
        endfunction

        function int outstanding();
            return awaited_wave.size();
        endfunction

        // a zero slot length behaves as a single tick
        function bit slot_ends();
            logic [7:0] len;
            len = (slot_len == 8'd0) ? 8'd1 : slot_len;
            tick_pos = tick_pos + 8'd1;
            if (tick_pos >= len) begin
                tick_pos = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void advance_wave(t_in_item it);
            t_out_item  r;
            logic       was_busy;
            logic       bit_val;
            logic [7:0] hi;
            r = '0;
            was_busy = (phase != SEND_IDLE);
            r.busy_res = was_busy;
            case (it.operation)
                OP_SET_COLOR: begin
                    if (was_busy) begin
                        r.rejected = 1'b1;
                    end else if (int'(it.pixel_index) < LED_COUNT_DEF) begin
                        pixels[int'(it.pixel_index)] = {it.green, it.red, it.blue};
                    end
                end
                OP_START: begin
                    if (was_busy) begin
                        r.rejected = 1'b1;
                    end else begin
                        phase      = SEND_DATA;
                        led_pos    = 0;
                        bit_pos    = 0;
                        tick_pos   = '0;
                        gap_cnt    = '0;
                        cur_bits   = pixels[0];
                        r.busy_res = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (phase == SEND_DATA) begin
                        bit_val = cur_bits[23 - bit_pos];
                        hi = bit_val ? one_high : zero_high;
                        r.line_level = (tick_pos < hi);
                        if (slot_ends()) begin
                            bit_pos++;
                            if (bit_pos >= BITS_PER_LED) begin
                                bit_pos = 0;
                                if (led_pos == LED_COUNT_DEF - 1) begin
                                    led_pos  = 0;
                                    cur_bits = '0;
                                    gap_cnt  = '0;
                                    // no latch gap: frame ends on the last data tick
                                    if (gap_slots == 8'd0) begin
                                        phase        = SEND_IDLE;
                                        r.frame_done = 1'b1;
                                    end else begin
                                        phase = SEND_GAP;
                                    end
                                end else begin
                                    led_pos++;
                                    cur_bits = pixels[led_pos];
                                end
                            end
                        end
                    end else if (phase == SEND_GAP) begin
                        if (slot_ends()) begin
                            gap_cnt = gap_cnt + 8'd1;
                            if (gap_cnt >= gap_slots) begin
                                gap_cnt      = '0;
                                phase        = SEND_IDLE;
                                r.frame_done = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            awaited_wave.push_back(r);
        endfunction

        function void check_bit(string name, logic want, logic got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s expected %0b got %0b", $time, name, want, got);
            end
        endfunction

        function void compare_wave(t_out_item got);
            t_out_item want;
            if (awaited_wave.size() == 0) begin
                failures++;
                $display("%0t: result transfer with none awaited, expected none got %b",
                         $time, got);
                return;
            end
            want = awaited_wave.pop_front();
            check_bit("line_level", want.line_level, got.line_level);
            check_bit("busy_res",   want.busy_res,   got.busy_res);
            check_bit("frame_done", want.frame_done, got.frame_done);
            check_bit("rejected",   want.rejected,   got.rejected);
        endfunction
    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel writes, a frame start and timer ticks into the LED chain driver,
// with random idle bursts on both channels, and checks every result transfer
// against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import aled_pkg::*;
    import led_wave_tb_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_ITEMS    = 120;
    localparam int NOISY_TICKS   = 900;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;
    bit        quiet     = 1'b0;

    t_led_wave_scoreboard sb;

    addressable_led_chain_driver_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in_item make_item(logic [1:0] op, logic [7:0] idx,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_in_item it;
        it.operation   = op;
        it.pixel_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        return it;
    endfunction

    // mostly in-range pixel writes, some dropped indexes, stray ticks and code 3
    function automatic t_in_item idle_item();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            return make_item(OP_SET_COLOR, 8'($urandom_range(0, LED_COUNT_DEF - 1)),
                             rand8(), rand8(), rand8());
        if (pick < 15)
            return make_item(OP_SET_COLOR, 8'($urandom_range(LED_COUNT_DEF, 255)),
                             rand8(), rand8(), rand8());
        if (pick < 17)
            return make_item(OP_TICK, rand8(), rand8(), rand8(), rand8());
        return make_item(OP_UNUSED, rand8(), rand8(), rand8(), rand8());
    endfunction

    function automatic t_in_item busy_noise();
        logic [1:0] op;
        case ($urandom_range(0, 2))
            0:       op = OP_SET_COLOR;
            1:       op = OP_START;
            default: op = OP_UNUSED;
        endcase
        return make_item(op, rand8(), rand8(), rand8(), rand8());
    endfunction

    // valid stays high between back-to-back transfers; dropped only for a gap
    task automatic push_item(input t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.advance_wave(it);
    endtask

    task automatic finish_frame(input bit noisy);
        while (sb.frame_active()) begin
            if (noisy && $urandom_range(0, 31) == 0)
                push_item(busy_noise());
            else
                push_item(make_item(OP_TICK, rand8(), rand8(), rand8(), rand8()));
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_timing(idx, val);
    endtask

    task automatic program_timing(input logic [7:0] one_t, input logic [7:0] zero_t,
                                  input logic [7:0] slot_t, input logic [7:0] gap_t);
        write_reg(CFG_ONE_HIGH, one_t);
        write_reg(CFG_ZERO_HIGH, zero_t);
        write_reg(CFG_SLOT_TICKS, slot_t);
        write_reg(CFG_RESET_SLOTS, gap_t);
        cfg_valid <= 1'b0;
    endtask

    // result side stalls in bursts, with stall-free runs between
    initial begin : out_stall_gen
        int n;
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                out_stall <= 1'b1;
            end else begin
                n = $urandom_range(1, 24);
                out_stall <= 1'b0;
            end
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.compare_wave(out_data);
    end

    initial begin : stimulus
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing: pixel writes at the index extremes, dropped indexes,
        // the unused code and a tick while idle
        push_item(make_item(OP_SET_COLOR, 8'd0, 8'hFF, 8'hFF, 8'hFF));
        push_item(make_item(OP_SET_COLOR, 8'd63, 8'h00, 8'hA5, 8'h5A));
        push_item(make_item(OP_SET_COLOR, 8'd64, 8'hFF, 8'hFF, 8'hFF));
        push_item(make_item(OP_SET_COLOR, 8'd255, 8'h00, 8'h00, 8'h00));
        push_item(make_item(OP_SET_COLOR, 8'd1, 8'h80, 8'h01, 8'h7E));
        push_item(make_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_item(make_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00));

        repeat (IDLE_ITEMS) push_item(idle_item());

        // zero slot length acts as one tick, so the wire follows each data bit;
        // one-bit high time equals the slot; writes and starts in flight rejected
        settle();
        program_timing(8'd1, 8'd0, 8'd0, 8'd3);
        push_item(make_item(OP_START, 8'h00, 8'h00, 8'h00, 8'h00));
        push_item(make_item(OP_SET_COLOR, 8'd2, 8'h12, 8'h34, 8'h56));
        push_item(make_item(OP_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_item(make_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00));
        repeat (NOISY_TICKS) begin
            if ($urandom_range(0, 31) == 0)
                push_item(busy_noise());
            else
                push_item(make_item(OP_TICK, rand8(), rand8(), rand8(), rand8()));
        end

        // rest of the frame without idling on either side
        quiet = 1'b1;
        finish_frame(1'b0);

        settle();
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #200_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
